// ===== sv/double_ended_queue_assert.svh =====
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Shared helpers for the concurrent checks in the queue modules.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Property that must hold on every clock edge outside reset.
`define DQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue package
// Depth, widths, command and status codes, and controller/datapath types.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

  parameter int DEPTH = 16;
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  parameter int CNT_W = $clog2(DEPTH + 1);
  parameter int DATA_W = 32;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_LIST       = 3'd4;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP_RD,
    ST_LIST_RD,
    ST_OUT
  } dq_state_e;

  typedef enum logic [1:0] {
    RD_FRONT,
    RD_BACK,
    RD_NEXT
  } dq_rd_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       wr_front;
    logic       wr_back;
    logic       pop_front;
    logic       pop_back;
    logic       rd_en;
    dq_rd_sel_e rd_sel;
    logic       list_clr;
    logic       list_inc;
    logic       ld_imm;
    logic [1:0] imm_status;
    logic       ld_rd;
    logic       rd_last;
  } dq_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic list_end;
    logic out_last;
  } dq_stat_t;

endpackage

`default_nettype wire

// ===== sv/dq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic                             re_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/dq_datapath.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Ring pointers, listing offset, entry store and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "double_ended_queue_assert.svh"

module dq_datapath
  import dq_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic signed [DATA_W-1:0] value_i,
  input  wire dq_ctrl_t                 ctrl_i,
  output      dq_stat_t                 stat_o,
  output      logic signed [DATA_W-1:0] data_o,
  output      logic [1:0]               status_o,
  output      logic                     last_o
);

  localparam logic [CNT_W:0] SUM_DEPTH = (CNT_W + 1)'(DEPTH);

  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] offset_q, offset_d;

  logic signed [DATA_W-1:0] data_q;
  logic [1:0]               status_q;
  logic                     last_q;

  logic [IDX_W-1:0]  front_dec;
  logic [IDX_W-1:0]  waddr;
  logic [IDX_W-1:0]  raddr;
  logic [CNT_W-1:0]  offset_ext;
  logic [DATA_W-1:0] rdata;

  // Ring position of the entry at a given distance from the front.
  function automatic logic [IDX_W-1:0] slot_of(logic [IDX_W-1:0] base,
                                               logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, off};
    if (sum >= SUM_DEPTH) begin
      sum = sum - SUM_DEPTH;
    end
    return sum[IDX_W-1:0];
  endfunction

  assign front_dec  = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
  assign offset_ext = {{(CNT_W - IDX_W){1'b0}}, offset_q};
  assign waddr      = ctrl_i.wr_front ? front_dec : slot_of(front_q, count_q);

  always_comb begin
    unique case (ctrl_i.rd_sel)
      RD_FRONT: raddr = front_q;
      RD_BACK:  raddr = slot_of(front_q, count_q - 1'b1);
      RD_NEXT:  raddr = slot_of(front_q, offset_ext + 1'b1);
      default:  raddr = front_q;
    endcase
  end

  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    offset_d = offset_q;
    if (ctrl_i.wr_front) begin
      front_d = front_dec;
    end else if (ctrl_i.pop_front) begin
      front_d = slot_of(front_q, CNT_W'(1));
    end
    if (ctrl_i.wr_front || ctrl_i.wr_back) begin
      count_d = count_q + 1'b1;
    end else if (ctrl_i.pop_front || ctrl_i.pop_back) begin
      count_d = count_q - 1'b1;
    end
    if (ctrl_i.list_clr) begin
      offset_d = '0;
    end else if (ctrl_i.list_inc) begin
      offset_d = offset_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      count_q  <= '0;
      offset_q <= '0;
    end else begin
      front_q  <= front_d;
      count_q  <= count_d;
      offset_q <= offset_d;
    end
  end

  // Result register: immediate answers carry zero data.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_imm) begin
      data_q   <= '0;
      status_q <= ctrl_i.imm_status;
      last_q   <= 1'b1;
    end else if (ctrl_i.ld_rd) begin
      data_q   <= rdata;
      status_q <= STATUS_OK;
      last_q   <= ctrl_i.rd_last;
    end
  end

  dq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.wr_front | ctrl_i.wr_back),
    .waddr_i (waddr),
    .wdata_i (value_i),
    .re_i    (ctrl_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign stat_o.full     = (count_q == CNT_W'(DEPTH));
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.list_end = ((offset_ext + 1'b1) == count_q);
  assign stat_o.out_last = last_q;

  assign data_o   = data_q;
  assign status_o = status_q;
  assign last_o   = last_q;

  `DQ_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "entry count above depth")
  `DQ_ASSERT(a_front_bound, front_q <= IDX_W'(DEPTH - 1), "front index out of ring")

endmodule

`default_nettype wire

// ===== sv/dq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Decodes commands, sequences store reads and hands results to the output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "double_ended_queue_assert.svh"

module dq_ctrl
  import dq_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire logic [2:0] cmd_i,
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  input  wire dq_stat_t   stat_i,
  output      dq_ctrl_t   ctrl_o
);

  dq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    ctrl_o.rd_sel = RD_FRONT;
    in_ready_o  = (state_q == ST_IDLE);
    out_valid_o = (state_q == ST_OUT);

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (cmd_i)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              ctrl_o.ld_imm = 1'b1;
              state_d       = ST_OUT;
              if (stat_i.full) begin
                ctrl_o.imm_status = STATUS_FULL;
              end else begin
                ctrl_o.imm_status = STATUS_OK;
                ctrl_o.wr_front   = (cmd_i == CMD_PUSH_FRONT);
                ctrl_o.wr_back    = (cmd_i == CMD_PUSH_BACK);
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (stat_i.empty) begin
                ctrl_o.ld_imm     = 1'b1;
                ctrl_o.imm_status = STATUS_EMPTY;
                state_d           = ST_OUT;
              end else begin
                // read at the old pointers, update them in the same cycle
                ctrl_o.rd_en     = 1'b1;
                ctrl_o.rd_sel    = (cmd_i == CMD_POP_FRONT) ? RD_FRONT : RD_BACK;
                ctrl_o.pop_front = (cmd_i == CMD_POP_FRONT);
                ctrl_o.pop_back  = (cmd_i == CMD_POP_BACK);
                state_d          = ST_POP_RD;
              end
            end
            CMD_LIST: begin
              if (stat_i.empty) begin
                ctrl_o.ld_imm     = 1'b1;
                ctrl_o.imm_status = STATUS_EMPTY;
                state_d           = ST_OUT;
              end else begin
                ctrl_o.rd_en    = 1'b1;
                ctrl_o.rd_sel   = RD_FRONT;
                ctrl_o.list_clr = 1'b1;
                state_d         = ST_LIST_RD;
              end
            end
            default: begin
              // drop unused codes without a result
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_POP_RD: begin
        ctrl_o.ld_rd   = 1'b1;
        ctrl_o.rd_last = 1'b1;
        state_d        = ST_OUT;
      end
      ST_LIST_RD: begin
        ctrl_o.ld_rd   = 1'b1;
        ctrl_o.rd_last = stat_i.list_end;
        state_d        = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) begin
          if (stat_i.out_last) begin
            state_d = ST_IDLE;
          end else begin
            // advance to the next entry of the listing
            ctrl_o.rd_en    = 1'b1;
            ctrl_o.rd_sel   = RD_NEXT;
            ctrl_o.list_inc = 1'b1;
            state_d         = ST_LIST_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `DQ_ASSERT(a_one_side, !(in_ready_o && out_valid_o), "input taken while result pending")
  `DQ_ASSERT_NEXT(a_read_to_out, state_q == ST_POP_RD || state_q == ST_LIST_RD,
                  state_q == ST_OUT, "read data not presented")
  `DQ_ASSERT_NEXT(a_list_continue, out_valid_o && out_ready_i && !stat_i.out_last,
                  state_q == ST_LIST_RD, "listing stopped before last entry")

endmodule

`default_nettype wire

// ===== sv/double_ended_queue.sv =====
// Bounded double-ended queue of signed 32-bit words in a ring buffer. The
// block takes one command at a time and accepts the next once every result
// of the current one has been transferred. A push, a rejected push, or an
// empty answer is presented in the cycle after acceptance; a pop reads the
// store in a read state before its result is presented, because the store
// is a RAM with registered read; a listing of N entries presents them one by
// one, each entry being read from the single RAM read port after the
// previous result is transferred. Unused command codes are accepted and produce no result.
// ----------------------------------------------------------------------------
// Double-ended queue top level
// Joins the command controller and the pointer and store datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue
  import dq_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output      logic                     in_ready_o,
  input  wire logic [2:0]               cmd_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  output      logic                     out_valid_o,
  input  wire logic                     out_ready_i,
  output      logic signed [DATA_W-1:0] data_o,
  output      logic [1:0]               status_o,
  output      logic                     last_o
);

  dq_ctrl_t ctrl;
  dq_stat_t stat;

  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  dq_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .value_i  (value_i),
    .ctrl_i   (ctrl),
    .stat_o   (stat),
    .data_o   (data_o),
    .status_o (status_o),
    .last_o   (last_o)
  );

endmodule

`default_nettype wire
